// File: sv/ppmfd_pkg.sv
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Shared types and constants for the PPM frame decoder block.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

    // Register indexes (word addresses on the configuration port).
    localparam int unsigned REG_AW = 2;
    localparam logic [REG_AW-1:0] REG_VERIFY_MODE    = 2'd0;
    localparam logic [REG_AW-1:0] REG_FIXED_CHANNELS = 2'd1;
    localparam logic [REG_AW-1:0] REG_AUTO_PACKETS   = 2'd2;
    localparam logic [REG_AW-1:0] REG_SERVO_CHANNEL  = 2'd3;

    // Packet verification modes.
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_FIRST_N = 2'd1;
    localparam logic [1:0] MODE_EXACT_N = 2'd2;
    localparam logic [1:0] MODE_AUTO    = 2'd3;

    // A length at or above this many microseconds is a sync pause.
    localparam logic [15:0] SYNC_US = 16'd3000;

    // Reciprocal of three scaled by 2^17, rounded up; exact for 17-bit values.
    localparam logic [16:0] RECIP_3 = 17'd43691;

    // No packet emits more than this many channel items.
    localparam int unsigned MAX_ITEMS = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture accepted: form the tick difference
        logic calc;   // convert ticks to microseconds
        logic eval;   // classify the edge, update state, load first result
        logic next;   // result taken and more follow: load the next channel
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_last;  // the result held in the output register is the final one
    } t_dp_status;

endpackage

// File: sv/ppmfd_regs.sv
// ----------------------------------------------------------------------------
// PPM frame decoder configuration registers
// APB-style register file holding the four decoder settings.
// ----------------------------------------------------------------------------
module ppmfd_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  o_verify_mode,
    output logic [3:0]  o_fixed_channels,
    output logic [3:0]  o_auto_packets,
    output logic [3:0]  o_servo_channel
);

    logic [1:0] r_verify_mode;
    logic [3:0] r_fixed_channels;
    logic [3:0] r_auto_packets;
    logic [3:0] r_servo_channel;
    logic       wr_en;
    logic [ppmfd_pkg::REG_AW-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verify_mode    <= '0;
            r_fixed_channels <= '0;
            r_auto_packets   <= '0;
            r_servo_channel  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                ppmfd_pkg::REG_VERIFY_MODE:    r_verify_mode    <= pwdata[1:0];
                ppmfd_pkg::REG_FIXED_CHANNELS: r_fixed_channels <= pwdata[3:0];
                ppmfd_pkg::REG_AUTO_PACKETS:   r_auto_packets   <= pwdata[3:0];
                ppmfd_pkg::REG_SERVO_CHANNEL:  r_servo_channel  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            ppmfd_pkg::REG_VERIFY_MODE:    prdata = {30'd0, r_verify_mode};
            ppmfd_pkg::REG_FIXED_CHANNELS: prdata = {28'd0, r_fixed_channels};
            ppmfd_pkg::REG_AUTO_PACKETS:   prdata = {28'd0, r_auto_packets};
            ppmfd_pkg::REG_SERVO_CHANNEL:  prdata = {28'd0, r_servo_channel};
            default:                       prdata = '0;
        endcase
    end

    assign o_verify_mode    = r_verify_mode;
    assign o_fixed_channels = r_fixed_channels;
    assign o_auto_packets   = r_auto_packets;
    assign o_servo_channel  = r_servo_channel;

endmodule

// File: sv/ppmfd_ctrl.sv
// ----------------------------------------------------------------------------
// PPM frame decoder controller
// State machine sequencing capture, conversion, evaluation and result output.
// ----------------------------------------------------------------------------
module ppmfd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    input  ppmfd_pkg::t_dp_status i_status,
    output ppmfd_pkg::t_dp_cmd    o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_take;
    logic       out_take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_take     = i_in_valid && o_in_ready;
    assign out_take    = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_take) n_state = S_LEN;
            S_LEN:  n_state = S_EVAL;
            S_EVAL: n_state = S_OUT;
            S_OUT:  if (out_take && i_status.out_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load = in_take;
    assign o_cmd.calc = (r_state == S_LEN);
    assign o_cmd.eval = (r_state == S_EVAL);
    assign o_cmd.next = out_take && !i_status.out_last;

endmodule

// File: sv/ppmfd_dpath.sv
// ----------------------------------------------------------------------------
// PPM frame decoder datapath
// Tick conversion, pulse buffer, packet verification and output register.
// ----------------------------------------------------------------------------
module ppmfd_dpath #(
    parameter int unsigned CHANNEL_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppmfd_pkg::t_dp_cmd    i_cmd,
    output ppmfd_pkg::t_dp_status o_status,
    input  logic [15:0]           i_capture_time,
    input  logic [1:0]            i_verify_mode,
    input  logic [3:0]            i_fixed_channels,
    input  logic [3:0]            i_auto_packets,
    input  logic [3:0]            i_servo_channel,
    output logic                  o_item_kind,
    output logic [2:0]            o_channel_index,
    output logic [11:0]           o_pulse_us,
    output logic [3:0]            o_packet_channels,
    output logic                  o_servo_pin,
    output logic                  o_last
);

    localparam int unsigned BUF_AW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
    localparam int unsigned CAP    = (CHANNEL_SLOTS < ppmfd_pkg::MAX_ITEMS) ?
                                     CHANNEL_SLOTS : ppmfd_pkg::MAX_ITEMS;

    // Edge state
    logic [15:0] r_prev_capture;
    logic [16:0] r_ticks2;
    logic [15:0] r_len;
    logic [7:0]  r_pulse_count;
    logic [7:0]  r_prev_packet_count;
    logic [3:0]  r_countdown;
    logic        r_servo;
    logic [11:0] r_buffer [CHANNEL_SLOTS];

    // Output register
    logic        r_out_kind;
    logic [2:0]  r_out_index;
    logic [11:0] r_out_pulse;
    logic [3:0]  r_out_count;
    logic        r_out_last;

    logic [33:0] product;
    logic        is_sync;
    logic [7:0]  pc_inc;
    logic [7:0]  n_count;
    logic [7:0]  n_prev_packet_count;
    logic [3:0]  n_countdown;
    logic [3:0]  n_cap;
    logic [2:0]  idx_next;
    logic [7:0]  servo_lo;

    assign product  = r_ticks2 * ppmfd_pkg::RECIP_3;
    assign is_sync  = (r_len >= ppmfd_pkg::SYNC_US);
    assign pc_inc   = (r_pulse_count != 8'hFF) ? r_pulse_count + 8'd1 : r_pulse_count;
    assign idx_next = r_out_index + 3'd1;
    assign servo_lo = {4'd0, i_servo_channel - 4'd1};

    // Verification of the pulse count at a sync pause.
    always_comb begin
        n_count             = r_pulse_count;
        n_prev_packet_count = r_prev_packet_count;
        n_countdown         = r_countdown;
        unique case (i_verify_mode)
            ppmfd_pkg::MODE_FIRST_N: begin
                if (r_pulse_count > {4'd0, i_fixed_channels}) begin
                    n_count = {4'd0, i_fixed_channels};
                end
            end
            ppmfd_pkg::MODE_EXACT_N: begin
                if (r_pulse_count != {4'd0, i_fixed_channels}) begin
                    n_count = '0;
                end
            end
            ppmfd_pkg::MODE_AUTO: begin
                if (r_pulse_count != r_prev_packet_count) begin
                    n_prev_packet_count = r_pulse_count;
                    n_countdown         = i_auto_packets;
                    n_count             = '0;
                end else if (r_countdown != 4'd0) begin
                    n_countdown = r_countdown - 4'd1;
                    n_count     = '0;
                end
            end
            default: begin
            end
        endcase
        n_cap = (n_count > 8'(CAP)) ? 4'(CAP) : n_count[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_capture      <= '0;
            r_pulse_count       <= '0;
            r_prev_packet_count <= '0;
            r_countdown         <= '0;
            r_servo             <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_capture <= i_capture_time;
            end
            if (i_cmd.eval) begin
                if (is_sync) begin
                    r_prev_packet_count <= n_prev_packet_count;
                    r_countdown         <= n_countdown;
                    r_pulse_count       <= '0;
                    if (i_servo_channel == 4'd1) begin
                        r_servo <= 1'b1;
                    end
                end else begin
                    r_pulse_count <= pc_inc;
                    if (i_servo_channel != 4'd0) begin
                        if (pc_inc == servo_lo) begin
                            r_servo <= 1'b1;
                        end else if (pc_inc == {4'd0, i_servo_channel}) begin
                            r_servo <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ticks2 <= {i_capture_time - r_prev_capture, 1'b0};
        end
        if (i_cmd.calc) begin
            r_len <= product[32:17];
        end
        if (i_cmd.eval) begin
            r_out_index <= '0;
            if (is_sync) begin
                r_out_kind  <= (n_cap != 4'd0);
                r_out_pulse <= (n_cap != 4'd0) ? r_buffer[BUF_AW'(3'd0)] : 12'd0;
                r_out_count <= n_cap;
                r_out_last  <= (n_cap <= 4'd1);
            end else begin
                if (r_pulse_count < 8'(CHANNEL_SLOTS)) begin
                    r_buffer[r_pulse_count[BUF_AW-1:0]] <= r_len[11:0];
                end
                r_out_kind  <= 1'b0;
                r_out_pulse <= '0;
                r_out_count <= '0;
                r_out_last  <= 1'b1;
            end
        end
        if (i_cmd.next) begin
            r_out_index <= idx_next;
            r_out_pulse <= r_buffer[BUF_AW'(idx_next)];
            r_out_last  <= ({1'b0, idx_next} + 4'd1 == r_out_count);
        end
    end

    assign o_status.out_last = r_out_last;
    assign o_item_kind       = r_out_kind;
    assign o_channel_index   = r_out_index;
    assign o_pulse_us        = r_out_pulse;
    assign o_packet_channels = r_out_count;
    assign o_servo_pin       = r_servo;
    assign o_last            = r_out_last;

endmodule

// File: sv/ppm_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// PPM frame decoder unit
// Decodes RC receiver PPM edge timestamps into verified channel packets.
// ----------------------------------------------------------------------------
// Each request on the input channel carries a 16-bit timer capture taken at a
// PPM edge, the timer ticking 1.5 times per microsecond. The unit takes the
// modulo-2^16 difference to the previous capture and converts it to whole
// microseconds. A length below 3000 us is a channel pulse, which is stored in
// the pulse buffer and answered by one status request; a longer length is a
// sync pause, at which the packet is verified in the configured mode and
// either its channels are sent (one request per channel, last flagging the
// final one) or a single status request is sent. The servo pin output mirrors
// the configured channel. Each capture passes through accept, conversion
// multiply and evaluation, then its results are sent one by one; a sync edge
// releases up to eight channels, and the output side may stall the unit. The
// controller works on one capture at a time, taking no new capture until the
// last result is taken, and walks the pulse buffer one entry per cycle while
// results are taken. Configuration must be written while the unit is idle.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_unit #(
    parameter int unsigned CHANNEL_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Capture input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_capture_time,
    // Result output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [2:0]  o_channel_index,
    output logic [11:0] o_pulse_us,
    output logic [3:0]  o_packet_channels,
    output logic        o_servo_pin,
    output logic        o_last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Settings held by the register file.
    logic [1:0] verify_mode;
    logic [3:0] fixed_channels;
    logic [3:0] auto_packets;
    logic [3:0] servo_channel;

    // The controller and datapath talk only through these two bundles.
    ppmfd_pkg::t_dp_cmd    dp_cmd;
    ppmfd_pkg::t_dp_status dp_status;

    ppmfd_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_verify_mode    (verify_mode),
        .o_fixed_channels (fixed_channels),
        .o_auto_packets   (auto_packets),
        .o_servo_channel  (servo_channel)
    );

    // The controller steps each capture through conversion and evaluation,
    // then holds the output valid until every result has been taken.
    ppmfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    ppmfd_dpath #(
        .CHANNEL_SLOTS (CHANNEL_SLOTS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_capture_time    (i_capture_time),
        .i_verify_mode     (verify_mode),
        .i_fixed_channels  (fixed_channels),
        .i_auto_packets    (auto_packets),
        .i_servo_channel   (servo_channel),
        .o_item_kind       (o_item_kind),
        .o_channel_index   (o_channel_index),
        .o_pulse_us        (o_pulse_us),
        .o_packet_channels (o_packet_channels),
        .o_servo_pin       (o_servo_pin),
        .o_last            (o_last)
    );

endmodule
